[design/pcw_pkg.sv]
// ----------------------------------------------------------------------------
// pcw_pkg
// shared types and constants of the png chunk walker
// ----------------------------------------------------------------------------
package pcw_pkg;

	localparam logic [1:0] KIND_SIG_OK  = 2'd0;
	localparam logic [1:0] KIND_CHUNK   = 2'd1;
	localparam logic [1:0] KIND_IHDR    = 2'd2;
	localparam logic [1:0] KIND_SIG_ERR = 2'd3;

	localparam logic [31:0] TYPE_IHDR = 32'h4948_4452;
	localparam logic [31:0] TYPE_IEND = 32'h4945_4E44;

	localparam logic [31:0] IHDR_LEN = 32'd13;
	localparam logic [32:0] CRC_LEN  = 33'd4;

	typedef enum logic [5:0] {
		PH_SIG  = 6'b000001,
		PH_HDR  = 6'b000010,
		PH_IHDR = 6'b000100,
		PH_SKIP = 6'b001000,
		PH_DONE = 6'b010000,
		PH_HALT = 6'b100000
	} phase_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [31:0] chunk_length;
		logic [31:0] chunk_type;
		logic [31:0] image_width;
		logic [31:0] image_height;
		logic [7:0]  sample_depth;
		logic [7:0]  color_kind;
		logic        stream_done;
	} result_t;

	function automatic logic [7:0] sig_byte(input logic [1:0] idx);
		logic [7:0] b;
		case (idx)
			2'd0: b = 8'h89;
			2'd1: b = 8'h50;
			2'd2: b = 8'h4E;
			2'd3: b = 8'h47;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

[design/pcw_out_buf.sv]
// ----------------------------------------------------------------------------
// pcw_out_buf
// two-entry result buffer: output register plus skid register
// ----------------------------------------------------------------------------
module pcw_out_buf (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  pcw_pkg::result_t push_data,
	output logic             full,
	output logic             out_valid,
	input  logic             out_stall,
	output pcw_pkg::result_t out_data
);

	logic             main_v_q;
	logic             skid_v_q;
	pcw_pkg::result_t main_q;
	pcw_pkg::result_t skid_q;
	logic             pop;

	assign pop       = main_v_q & ~out_stall;
	assign full      = skid_v_q;
	assign out_valid = main_v_q;
	assign out_data  = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (skid_v_q) begin
			if (pop) begin
				skid_v_q <= 1'b0;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_v_q <= 1'b1;
			end else begin
				main_v_q <= 1'b1;
			end
		end else if (pop) begin
			main_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_v_q) begin
			if (pop) begin
				main_q <= skid_q;
			end
		end else if (push) begin
			if (main_v_q && !pop) begin
				skid_q <= push_data;
			end else begin
				main_q <= push_data;
			end
		end
	end

endmodule

[design/png_chunk_walker.sv]
// ----------------------------------------------------------------------------
// png_chunk_walker
// byte-serial png signature check and chunk header walker
// ----------------------------------------------------------------------------
// a result is written to the output register, or to the skid register while the output register is stalled
// throughput: one byte per cycle unless in_stall holds input back while the skid register is full
// a two-entry result buffer keeps bytes flowing while a result waits
// reset: asynchronous, returns to the signature phase with counters cleared
// ----------------------------------------------------------------------------
module png_chunk_walker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [31:0] chunk_length,
	output logic [31:0] chunk_type,
	output logic [31:0] image_width,
	output logic [31:0] image_height,
	output logic [7:0]  sample_depth,
	output logic [7:0]  color_kind,
	output logic        stream_done
);

	pcw_pkg::phase_t  phase_q, phase_n;
	logic [32:0]      cnt_q, cnt_n;
	logic             bad_q, bad_n;
	logic [31:0]      len_q, len_n;
	logic [31:0]      type_q, type_n;
	logic [31:0]      width_q, width_n;
	logic [31:0]      height_q, height_n;
	logic [7:0]       depth_q, depth_n;
	logic [7:0]       colour_q, colour_n;
	logic             accept;
	logic             push;
	logic             buf_full;
	logic [32:0]      skip_dec;
	pcw_pkg::result_t res;
	pcw_pkg::result_t out_res;

	assign in_stall = buf_full;
	assign accept   = in_valid & ~buf_full;
	assign skip_dec = (cnt_q != 33'd0) ? (cnt_q - 33'd1) : cnt_q;

	always_comb begin
		phase_n  = phase_q;
		cnt_n    = cnt_q;
		bad_n    = bad_q;
		len_n    = len_q;
		type_n   = type_q;
		width_n  = width_q;
		height_n = height_q;
		depth_n  = depth_q;
		colour_n = colour_q;
		push     = 1'b0;
		res      = '0;
		if (accept) begin
			case (phase_q)
				pcw_pkg::PH_SIG: begin
					if (cnt_q[3:0] < 4'd4 && data_byte != pcw_pkg::sig_byte(cnt_q[1:0])) begin
						bad_n = 1'b1;
					end
					if (cnt_q[3:0] >= 4'd7) begin
						push            = 1'b1;
						res.result_kind = bad_n ? pcw_pkg::KIND_SIG_ERR : pcw_pkg::KIND_SIG_OK;
						cnt_n           = 33'd0;
						phase_n         = bad_n ? pcw_pkg::PH_HALT : pcw_pkg::PH_HDR;
					end else begin
						cnt_n = cnt_q + 33'd1;
					end
				end
				pcw_pkg::PH_HDR: begin
					if (cnt_q[3:0] < 4'd4) begin
						len_n = {len_q[23:0], data_byte};
					end else begin
						type_n = {type_q[23:0], data_byte};
					end
					if (cnt_q[3:0] >= 4'd7) begin
						push             = 1'b1;
						res.result_kind  = pcw_pkg::KIND_CHUNK;
						res.chunk_length = len_n;
						res.chunk_type   = type_n;
						res.stream_done  = (type_n == pcw_pkg::TYPE_IEND);
						cnt_n            = 33'd0;
						if (type_n == pcw_pkg::TYPE_IEND) begin
							phase_n = pcw_pkg::PH_DONE;
						end else if (type_n == pcw_pkg::TYPE_IHDR) begin
							phase_n = pcw_pkg::PH_IHDR;
						end else begin
							cnt_n   = {1'b0, len_n} + pcw_pkg::CRC_LEN;
							phase_n = pcw_pkg::PH_SKIP;
						end
					end else begin
						cnt_n = cnt_q + 33'd1;
					end
				end
				pcw_pkg::PH_IHDR: begin
					if (cnt_q[3:0] < 4'd4) begin
						width_n = {width_q[23:0], data_byte};
					end else if (cnt_q[3:0] < 4'd8) begin
						height_n = {height_q[23:0], data_byte};
					end else if (cnt_q[3:0] == 4'd8) begin
						depth_n = data_byte;
					end else if (cnt_q[3:0] == 4'd9) begin
						colour_n = data_byte;
					end
					if (cnt_q[3:0] >= 4'd12) begin
						push             = 1'b1;
						res.result_kind  = pcw_pkg::KIND_IHDR;
						res.image_width  = width_n;
						res.image_height = height_n;
						res.sample_depth = depth_n;
						res.color_kind   = colour_n;
						if (len_q >= pcw_pkg::IHDR_LEN) begin
							cnt_n = {1'b0, len_q - pcw_pkg::IHDR_LEN} + pcw_pkg::CRC_LEN;
						end else begin
							cnt_n = pcw_pkg::CRC_LEN;
						end
						phase_n = pcw_pkg::PH_SKIP;
					end else begin
						cnt_n = cnt_q + 33'd1;
					end
				end
				pcw_pkg::PH_SKIP: begin
					cnt_n = skip_dec;
					if (skip_dec == 33'd0) begin
						phase_n = pcw_pkg::PH_HDR;
					end
				end
				default: begin
					phase_n = phase_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= pcw_pkg::PH_SIG;
			cnt_q    <= 33'd0;
			bad_q    <= 1'b0;
			len_q    <= 32'd0;
			type_q   <= 32'd0;
			width_q  <= 32'd0;
			height_q <= 32'd0;
			depth_q  <= 8'd0;
			colour_q <= 8'd0;
		end else begin
			phase_q  <= phase_n;
			cnt_q    <= cnt_n;
			bad_q    <= bad_n;
			len_q    <= len_n;
			type_q   <= type_n;
			width_q  <= width_n;
			height_q <= height_n;
			depth_q  <= depth_n;
			colour_q <= colour_n;
		end
	end

	pcw_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (res),
		.full      (buf_full),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_res)
	);

	assign result_kind  = out_res.result_kind;
	assign chunk_length = out_res.chunk_length;
	assign chunk_type   = out_res.chunk_type;
	assign image_width  = out_res.image_width;
	assign image_height = out_res.image_height;
	assign sample_depth = out_res.sample_depth;
	assign color_kind   = out_res.color_kind;
	assign stream_done  = out_res.stream_done;

endmodule

[tb/sv/png_walk_checker.sv]
// ----------------------------------------------------------------------------
// png_walk_checker
// request and result monitor with a byte-level prediction of the chunk walker
// ----------------------------------------------------------------------------
// follows every accepted byte through its own signature, header, image
// header and skip tracking, queues the result each byte should produce and
// compares every accepted result field by field against the oldest entry
// ----------------------------------------------------------------------------
module png_walk_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	input  logic        in_stall,
	input  logic [7:0]  data_byte,
	input  logic        out_valid,
	input  logic        out_stall,
	input  logic [1:0]  result_kind,
	input  logic [31:0] chunk_length,
	input  logic [31:0] chunk_type,
	input  logic [31:0] image_width,
	input  logic [31:0] image_height,
	input  logic [7:0]  sample_depth,
	input  logic [7:0]  color_kind,
	input  logic        stream_done,
	output int          mismatches,
	output int          outstanding,
	output int          chunk_headers,
	output int          image_headers
);
	import pcw_pkg::*;

	localparam logic [31:0] PNG_MAGIC = 32'h8950_4E47;

	phase_t      walk_phase;
	logic [32:0] walk_count;
	logic        magic_bad;
	logic [31:0] hdr_length;
	logic [31:0] hdr_type;
	logic [31:0] img_width;
	logic [31:0] img_height;
	logic [7:0]  img_depth;
	logic [7:0]  img_color;

	result_t     expected_q[$];
	result_t     seen_res;
	result_t     want_res;
	result_t     pred_res;
	logic        pred_emit;

	int err_count = 0;
	int queued = 0;
	int hdr_seen = 0;
	int ihdr_seen = 0;

	assign mismatches    = err_count;
	assign outstanding   = queued;
	assign chunk_headers = hdr_seen;
	assign image_headers = ihdr_seen;

	task automatic note_mismatch(input string msg);
		err_count++;
		$display("tb: mismatch at %0t: %s", $time, msg);
	endtask

	task automatic check_field(input string name, input logic [31:0] got,
		input logic [31:0] want);
		if (got !== want)
			note_mismatch($sformatf("%s got %h want %h", name, got, want));
	endtask

	task automatic parse_byte(input logic [7:0] b, output logic emit,
		output result_t res);
		emit = 1'b0;
		res = '0;
		case (walk_phase)
		PH_SIG: begin
			if (walk_count < 33'd4 && b != PNG_MAGIC[8 * (3 - walk_count[1:0]) +: 8])
				magic_bad = 1'b1;
			if (walk_count >= 33'd7) begin
				emit = 1'b1;
				res.result_kind = magic_bad ? KIND_SIG_ERR : KIND_SIG_OK;
				walk_count = '0;
				walk_phase = magic_bad ? PH_HALT : PH_HDR;
			end else begin
				walk_count++;
			end
		end
		PH_HDR: begin
			if (walk_count < 33'd4)
				hdr_length = {hdr_length[23:0], b};
			else
				hdr_type = {hdr_type[23:0], b};
			if (walk_count >= 33'd7) begin
				emit = 1'b1;
				res.result_kind  = KIND_CHUNK;
				res.chunk_length = hdr_length;
				res.chunk_type   = hdr_type;
				res.stream_done  = (hdr_type == TYPE_IEND);
				walk_count = '0;
				if (hdr_type == TYPE_IEND) begin
					walk_phase = PH_DONE;
				end else if (hdr_type == TYPE_IHDR) begin
					walk_phase = PH_IHDR;
				end else begin
					walk_count = {1'b0, hdr_length} + CRC_LEN;
					walk_phase = PH_SKIP;
				end
			end else begin
				walk_count++;
			end
		end
		PH_IHDR: begin
			if (walk_count < 33'd4)
				img_width = {img_width[23:0], b};
			else if (walk_count < 33'd8)
				img_height = {img_height[23:0], b};
			else if (walk_count == 33'd8)
				img_depth = b;
			else if (walk_count == 33'd9)
				img_color = b;
			if (walk_count >= 33'd12) begin
				emit = 1'b1;
				res.result_kind  = KIND_IHDR;
				res.image_width  = img_width;
				res.image_height = img_height;
				res.sample_depth = img_depth;
				res.color_kind   = img_color;
				// long image header: its extra bytes and the crc are left to skip; short one: only the crc
				walk_count = (hdr_length >= IHDR_LEN) ?
					{1'b0, hdr_length - IHDR_LEN} + CRC_LEN : CRC_LEN;
				walk_phase = PH_SKIP;
			end else begin
				walk_count++;
			end
		end
		PH_SKIP: begin
			if (walk_count != '0)
				walk_count--;
			if (walk_count == '0)
				walk_phase = PH_HDR;
		end
		default: begin
		end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_phase = PH_SIG;
			walk_count = '0;
			magic_bad  = 1'b0;
			hdr_length = '0;
			hdr_type   = '0;
			img_width  = '0;
			img_height = '0;
			img_depth  = '0;
			img_color  = '0;
			expected_q.delete();
			queued = 0;
		end else begin
			if (out_valid && !out_stall) begin
				seen_res = {result_kind, chunk_length, chunk_type, image_width,
					image_height, sample_depth, color_kind, stream_done};
				if (expected_q.size() == 0) begin
					note_mismatch($sformatf("result of kind %0d with none pending",
						result_kind));
				end else begin
					want_res = expected_q.pop_front();
					check_field("result_kind", seen_res.result_kind, want_res.result_kind);
					check_field("chunk_length", seen_res.chunk_length, want_res.chunk_length);
					check_field("chunk_type", seen_res.chunk_type, want_res.chunk_type);
					check_field("image_width", seen_res.image_width, want_res.image_width);
					check_field("image_height", seen_res.image_height, want_res.image_height);
					check_field("sample_depth", seen_res.sample_depth, want_res.sample_depth);
					check_field("color_kind", seen_res.color_kind, want_res.color_kind);
					check_field("stream_done", seen_res.stream_done, want_res.stream_done);
					if (want_res.result_kind == KIND_CHUNK)
						hdr_seen++;
					if (want_res.result_kind == KIND_IHDR)
						ihdr_seen++;
				end
			end
			if (in_valid && !in_stall) begin
				parse_byte(data_byte, pred_emit, pred_res);
				if (pred_emit)
					expected_q.push_back(pred_res);
			end
			queued = expected_q.size();
		end
	end

endmodule

[tb/sv/tb_png_chunk_walker.sv]
// ----------------------------------------------------------------------------
// tb_png_chunk_walker
// byte stream stimulus and verdict for the png chunk walker
// ----------------------------------------------------------------------------
// builds one png-like stream: the signature with free trailing bytes, an
// image header with extreme fields, then chunks of random type, length and
// content (short, exact and long image headers among them), a burst of empty
// chunks under a long output hold-off, the end marker and trailing bytes the
// block must ignore; the checker beside the block predicts every result
// ----------------------------------------------------------------------------
module tb_png_chunk_walker;
	import pcw_pkg::*;

	localparam logic [31:0] SIG_HEAD = 32'h8950_4E47;
	localparam int HOLD_CYCLES = 400;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic [7:0]  data_byte = 8'h00;
	logic        out_stall = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  result_kind;
	logic [31:0] chunk_length;
	logic [31:0] chunk_type;
	logic [31:0] image_width;
	logic [31:0] image_height;
	logic [7:0]  sample_depth;
	logic [7:0]  color_kind;
	logic        stream_done;

	int mismatches;
	int outstanding;
	int chunk_headers;
	int image_headers;

	logic [7:0] stream_q[$];
	int   send_pct = 0;
	int   recv_pct = 0;
	logic hold_go = 1'b0;
	logic hold_taken = 1'b0;
	int   hold_left = 0;

	png_chunk_walker u_top (.*);

	png_walk_checker u_checker (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	initial begin
		#2_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic logic [7:0] rand_letter();
		return 8'h41 + 8'($urandom_range(25)) + ($urandom_range(1) ? 8'h20 : 8'h00);
	endfunction

	function automatic logic [31:0] rand_type();
		logic [31:0] t;
		int pick;
		pick = $urandom_range(99);
		if (pick < 25)
			t = TYPE_IHDR;
		else if (pick < 40)
			t = (pick[0] ? TYPE_IHDR : TYPE_IEND) ^ (32'd1 << $urandom_range(31));
		else if (pick < 70)
			t = {rand_letter(), rand_letter(), rand_letter(), rand_letter()};
		else
			t = $urandom;
		// the end marker only closes the stream
		if (t == TYPE_IEND)
			t[0] = ~t[0];
		return t;
	endfunction

	task automatic push_word(input logic [31:0] w);
		stream_q.push_back(w[31:24]);
		stream_q.push_back(w[23:16]);
		stream_q.push_back(w[15:8]);
		stream_q.push_back(w[7:0]);
	endtask

	task automatic push_chunk(input logic [31:0] len, input logic [31:0] typ,
		input logic [31:0] wid, input logic [31:0] hgt, input logic [7:0] dep,
		input logic [7:0] col);
		int body;
		push_word(len);
		push_word(typ);
		body = len;
		if (typ == TYPE_IHDR) begin
			push_word(wid);
			push_word(hgt);
			stream_q.push_back(dep);
			stream_q.push_back(col);
			repeat (3) stream_q.push_back(8'($urandom));
			body = (len > IHDR_LEN) ? len - IHDR_LEN : 0;
		end
		repeat (body + 4) stream_q.push_back(8'($urandom));
	endtask

	task automatic add_random_chunk();
		logic [31:0] typ;
		logic [31:0] len;
		int pick;
		typ = rand_type();
		pick = $urandom_range(99);
		if (typ == TYPE_IHDR)
			len = (pick < 60) ? IHDR_LEN : (pick < 80) ? $urandom_range(12) :
				$urandom_range(40, 14);
		else
			len = (pick < 50) ? $urandom_range(8) : (pick < 85) ?
				$urandom_range(40, 9) : $urandom_range(300, 41);
		push_chunk(len, typ, $urandom, $urandom, 8'($urandom), 8'($urandom));
	endtask

	always @(negedge clk) begin
		if (hold_go && !hold_taken) begin
			hold_taken = 1'b1;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < recv_pct);
		end
	end

	initial begin
		int idx;
		int hold_at;
		int burst_end;
		int tail_at;

		// signature, the last four bytes are not checked
		push_word(SIG_HEAD);
		push_word($urandom);
		push_chunk(IHDR_LEN, TYPE_IHDR, 32'hFFFF_FFFF, 32'h0, 8'hFF, 8'h00);

		// short, long and empty shapes first, then free mix
		push_chunk(32'd0, TYPE_IHDR, 32'h0, 32'hFFFF_FFFF, 8'h00, 8'hFF);
		push_chunk($urandom_range(40, 14), TYPE_IHDR, $urandom, $urandom,
			8'($urandom), 8'($urandom));
		push_chunk(32'd0, rand_type() ^ TYPE_IHDR ^ TYPE_IHDR, $urandom, $urandom,
			8'($urandom), 8'($urandom));
		while (stream_q.size() < 1600)
			add_random_chunk();

		// empty chunks to fill the block while results are held back
		hold_at = stream_q.size();
		repeat (14)
			push_chunk(32'd0, rand_type(), $urandom, $urandom, 8'($urandom),
				8'($urandom));
		burst_end = stream_q.size();
		while (stream_q.size() < 1830)
			add_random_chunk();

		push_word(32'd0);
		push_word(TYPE_IEND);
		tail_at = stream_q.size();
		push_word(32'd13);
		push_word(TYPE_IHDR);
		repeat (8) stream_q.push_back(8'($urandom));

		repeat (2) @(negedge clk);
		arst_n <= 1'b1;

		for (idx = 0; idx < stream_q.size(); idx++) begin
			if (idx < hold_at) begin
				case (idx * 4 / hold_at)
				0: begin
					send_pct = 0;
					recv_pct <= 0;
				end
				1: begin
					send_pct = 52;
					recv_pct <= 0;
				end
				2: begin
					send_pct = 0;
					recv_pct <= 52;
				end
				default: begin
					send_pct = 29;
					recv_pct <= 29;
				end
				endcase
			end else if (idx < burst_end) begin
				send_pct = 0;
				recv_pct <= 0;
			end else begin
				send_pct = 29;
				recv_pct <= 29;
			end
			if (idx == hold_at)
				hold_go <= 1'b1;
			while ($urandom_range(99) < send_pct) begin
				in_valid <= 1'b0;
				@(negedge clk);
			end
			in_valid <= 1'b1;
			data_byte <= stream_q[idx];
			do @(posedge clk); while (in_stall);
			@(negedge clk);
		end
		in_valid <= 1'b0;

		wait (outstanding == 0);
		repeat (10) @(posedge clk);
		$display("tb: walked %0d stream bytes, %0d of them after the end marker",
			stream_q.size(), stream_q.size() - tail_at);
		$display("tb: %0d chunk headers and %0d image headers under idle, stall and hold-off",
			chunk_headers, image_headers);
		if (mismatches + outstanding == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

[sim.f]
design/pcw_pkg.sv
design/pcw_out_buf.sv
design/png_chunk_walker.sv
tb/sv/png_walk_checker.sv
tb/sv/tb_png_chunk_walker.sv
